### hdl/dlc_pkg.sv
// Shared types, event codes and field layout for the display list coprocessor.
// Used by dlc_exec, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dlc_pkg;

	localparam int ADDR_BITS_DEF = 21;

	// Field widths fixed by the stream and register layout.
	localparam int KIND_W  = 2;
	localparam int LINE_W  = 9;
	localparam int POS_W   = 8;
	localparam int WORD_W  = 16;
	localparam int FETCH_W = 21;
	localparam int OFF_W   = 9;
	localparam int EV_W    = 3;
	localparam int DL_W    = 2;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 64;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SLOT    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_JUMP    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

	// Result events.
	localparam logic [EV_W-1:0] EV_RELOAD   = 3'd0;
	localparam logic [EV_W-1:0] EV_HOLD     = 3'd1;
	localparam logic [EV_W-1:0] EV_RELEASE  = 3'd2;
	localparam logic [EV_W-1:0] EV_WRITE    = 3'd3;
	localparam logic [EV_W-1:0] EV_STOP     = 3'd4;
	localparam logic [EV_W-1:0] EV_ARMED    = 3'd5;
	localparam logic [EV_W-1:0] EV_SKIP_NO  = 3'd6;
	localparam logic [EV_W-1:0] EV_SKIP_YES = 3'd7;

	// Configuration register indexes (byte address 4*index).
	localparam logic [1:0] REG_LIST_START = 2'd0;
	localparam logic [1:0] REG_DANGER     = 2'd1;
	localparam logic [1:0] REG_LAST_H     = 2'd2;

	localparam logic [POS_W-1:0] LAST_H_RESET = 8'd227;
	localparam logic [POS_W-1:0] STOP_LINE    = 8'hff;
	localparam logic [POS_W-1:0] STOP_COLUMN  = 8'hfe;
	localparam logic [POS_W-1:0] FLOOR_BASE   = 8'h80;

	typedef struct packed {
		logic [FETCH_W-1:0] list_start;
		logic [DL_W-1:0]    danger_level;
		logic [POS_W-1:0]   last_h;
	} dlc_cfg_t;

	typedef struct packed {
		logic             waiting;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] column;
		logic             blitter;
	} dlc_wait_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LINE_W-1:0]  beam_v;
		logic [POS_W-1:0]   beam_h;
		logic               blitter_busy;
		logic [WORD_W-1:0]  instr_word;
		logic [WORD_W-1:0]  param_word;
		logic [FETCH_W-1:0] jump_address;
	} dlc_item_t;

	typedef struct packed {
		logic [EV_W-1:0]    event_res;
		logic [OFF_W-1:0]   reg_offset;
		logic [WORD_W-1:0]  reg_data;
		logic [FETCH_W-1:0] fetch_address;
		logic               hold_rest_of_line;
		logic [POS_W-1:0]   release_h;
	} dlc_result_t;

endpackage

`default_nettype wire

### hdl/dlc_exec.sv
// Single-slot execution logic: decodes MOVE / WAIT / SKIP and the reload kinds,
// producing the next counter, the next wait state and the result. Uses dlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlc_exec import dlc_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire dlc_cfg_t             cfg,
	input  wire dlc_item_t            item,
	input  wire logic [ADDR_BITS-1:0] pc,
	input  wire dlc_wait_t            wst,
	output logic [ADDR_BITS-1:0]      pc_next,
	output dlc_wait_t                 wst_next,
	output dlc_result_t               res
);

	logic [POS_W-1:0]     v;
	logic [POS_W-1:0]     h;
	logic [ADDR_BITS-1:0] pc_plus4;
	logic [ADDR_BITS-1:0] pc_plus8;
	logic [OFF_W-1:0]     off;
	logic [POS_W-1:0]     floor_off;
	logic [POS_W-1:0]     pv;
	logic [POS_W-1:0]     ph;
	logic                 blit;
	logic                 pos_not_reached;

	assign v         = item.beam_v[POS_W-1:0];
	assign h         = item.beam_h;
	assign pc_plus4  = pc + ADDR_BITS'(4);
	assign pc_plus8  = pc + ADDR_BITS'(8);
	assign off       = {item.instr_word[OFF_W-1:1], 1'b0};
	assign floor_off = FLOOR_BASE - {1'b0, cfg.danger_level, 5'd0};
	// Vertical bit 7 of a WAIT/SKIP position is never masked.
	assign pv   = item.instr_word[15:8] & {1'b1, item.param_word[14:8]};
	assign ph   = item.instr_word[7:0] & STOP_COLUMN & item.param_word[7:0];
	assign blit = ~item.param_word[15];
	assign pos_not_reached = (v < pv) || ((v == pv) && (h < ph));

	always_comb begin
		pc_next  = pc;
		wst_next = wst;
		res      = '0;

		case (item.kind)
			KIND_RESTART, KIND_JUMP: begin
				pc_next = (item.kind == KIND_RESTART) ? ADDR_BITS'(cfg.list_start)
				                                      : ADDR_BITS'(item.jump_address);
				wst_next.waiting = 1'b0;
				res.event_res    = EV_RELOAD;
			end
			KIND_SLOT: begin
				if (wst.waiting) begin
					res.event_res = EV_HOLD;
					if (v < wst.line) begin
						res.hold_rest_of_line = 1'b1;
					end else if ((v == wst.line) && (h < wst.column)) begin
						if (wst.column > cfg.last_h)
							res.hold_rest_of_line = 1'b1;
						else
							res.release_h = wst.column;
					end else if (wst.blitter && item.blitter_busy) begin
						res.hold_rest_of_line = 1'b1;
					end else begin
						wst_next.blitter = 1'b0;
						wst_next.waiting = 1'b0;
						pc_next          = pc_plus4;
						res.event_res    = EV_RELEASE;
					end
				end else if (!item.instr_word[0]) begin
					pc_next = pc_plus4;
					if (off >= {1'b0, floor_off}) begin
						res.event_res  = EV_WRITE;
						res.reg_offset = off;
						res.reg_data   = item.param_word;
					end else begin
						// A protected register parks the list on a wait for line 0xff, column 0xfe.
						wst_next.waiting = 1'b1;
						wst_next.line    = STOP_LINE;
						wst_next.column  = STOP_COLUMN;
						res.event_res    = EV_STOP;
					end
				end else if (!item.param_word[0]) begin
					wst_next.waiting = 1'b1;
					wst_next.line    = pv;
					wst_next.column  = ph;
					wst_next.blitter = blit;
					res.event_res    = EV_ARMED;
				end else if (pos_not_reached || (blit && item.blitter_busy)) begin
					pc_next       = pc_plus4;
					res.event_res = EV_SKIP_NO;
				end else begin
					pc_next       = pc_plus8;
					res.event_res = EV_SKIP_YES;
				end
			end
			default: begin
			end
		endcase

		res.fetch_address = FETCH_W'(pc_next);
	end

endmodule

`default_nettype wire

### hdl/display_list_coprocessor.sv
// Display list coprocessor: one result item per accepted item of kind 0, 1 or 2.
// Each accepted item is held in the input register and executes into the result register, which drives m_tvalid.
// Throughput: one item per cycle; the input register and the result register
// advance together, so a stall on m_tready backs up into s_tready.
// Items of the unused kind are taken and dropped. Reset (arst_n low) clears
// the counter, the wait state, both valid flags and the configuration registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module display_list_coprocessor import dlc_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// beam_v, beam_h, blitter_busy, instr_word, param_word, jump_address, pad
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// kind
	input  wire logic [KIND_W-1:0]     s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// event_res, reg_offset, reg_data, fetch_address, hold_rest_of_line, release_h, pad
	output logic [M_TDATA_W-1:0]       m_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [3:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	dlc_cfg_t             cfg_q;
	dlc_item_t            item_s1;
	logic                 valid_s1;
	dlc_result_t          res_s2;
	logic                 valid_s2;
	logic [ADDR_BITS-1:0] pc_q;
	dlc_wait_t            wst_q;

	logic [ADDR_BITS-1:0] pc_next;
	dlc_wait_t            wst_next;
	dlc_result_t          res_next;
	logic                 advance;
	logic                 s_fire;
	dlc_item_t            item_in;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.list_start   <= '0;
			cfg_q.danger_level <= '0;
			cfg_q.last_h       <= LAST_H_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_LIST_START: cfg_q.list_start   <= pwdata[FETCH_W-1:0];
				REG_DANGER:     cfg_q.danger_level <= pwdata[DL_W-1:0];
				REG_LAST_H:     cfg_q.last_h       <= pwdata[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LIST_START: prdata = 32'(cfg_q.list_start);
			REG_DANGER:     prdata = 32'(cfg_q.danger_level);
			REG_LAST_H:     prdata = 32'(cfg_q.last_h);
			default:        prdata = '0;
		endcase
	end

	assign item_in.kind         = s_tuser;
	assign item_in.beam_v       = s_tdata[8:0];
	assign item_in.beam_h       = s_tdata[16:9];
	assign item_in.blitter_busy = s_tdata[17];
	assign item_in.instr_word   = s_tdata[33:18];
	assign item_in.param_word   = s_tdata[49:34];
	assign item_in.jump_address = s_tdata[70:50];

	// The slot in the input register executes when the result register frees up.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	dlc_exec #(
		.ADDR_BITS(ADDR_BITS)
	) u_exec (
		.cfg      (cfg_q),
		.item     (item_s1),
		.pc       (pc_q),
		.wst      (wst_q),
		.pc_next  (pc_next),
		.wst_next (wst_next),
		.res      (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q     <= '0;
			wst_q    <= '0;
		end else begin
			if (s_fire)
				valid_s1 <= (s_tuser != KIND_UNUSED);
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance) begin
				valid_s2 <= 1'b1;
				pc_q     <= pc_next;
				wst_q    <= wst_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			item_s1 <= item_in;
		if (advance)
			res_s2 <= res_next;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.release_h, res_s2.hold_rest_of_line,
	                   res_s2.fetch_address, res_s2.reg_data, res_s2.reg_offset,
	                   res_s2.event_res};

endmodule

`default_nettype wire

### hdl/dlc_checker.sv
// Port-level checker for display_list_coprocessor, attached by bind.
// Uses the event codes of dlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlc_checker import dlc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	logic [EV_W-1:0] ev;

	assign ev = m_tdata[2:0];

	// A stalled result stays offered.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// Register offset and data are zero on every event but a write.
	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ev != EV_WRITE) |-> (m_tdata[27:3] == '0))
		else $error("write fields set on a non-write event");

	// Hold details only accompany a holding event.
	a_hold_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ev != EV_HOLD) |-> (m_tdata[57:49] == '0))
		else $error("hold fields set on a non-hold event");

	// A write never reaches a register below the lowest possible floor.
	a_write_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ev == EV_WRITE) |-> !m_tdata[3] && (m_tdata[11:3] >= 9'h020))
		else $error("write below the protected floor");

	// A holding result never offers both a release column and rest-of-line.
	a_hold_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[49] |-> (m_tdata[57:50] == '0))
		else $error("release column given while holding for the rest of the line");

endmodule

bind display_list_coprocessor dlc_checker u_dlc_checker (.*);

`default_nettype wire

### dv/tb_display_list_coprocessor.sv
// Self-checking testbench for display_list_coprocessor: directed slot sequences and random phases.
// Depends on dlc_pkg and the RTL only; expected results come from an in-bench model of the block.
`timescale 1ns / 1ps

module tb_display_list_coprocessor;
	import dlc_pkg::*;

	localparam logic [FETCH_W-1:0] STEP_ONE = 21'd4;
	localparam logic [FETCH_W-1:0] STEP_TWO = 21'd8;
	localparam int DRAIN_CYCLES = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// beam_v, beam_h, blitter_busy, instr_word, param_word, jump_address, pad
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// kind
	logic [KIND_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// event_res, reg_offset, reg_data, fetch_address, hold_rest_of_line, release_h, pad
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [3:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// Copy of the block's configuration and list state.
	logic [FETCH_W-1:0] cfg_list_start = '0;
	logic [DL_W-1:0]    cfg_danger = '0;
	logic [POS_W-1:0]   cfg_last_h = LAST_H_RESET;
	logic [FETCH_W-1:0] list_pc = '0;
	logic               list_waiting = 1'b0;
	logic [POS_W-1:0]   wait_v = '0;
	logic [POS_W-1:0]   wait_h = '0;
	logic               wait_blit = 1'b0;

	dlc_result_t due_results[$];
	int fail_count = 0;
	bit idle_on = 1'b1;
	int rx_stall = 0;

	display_list_coprocessor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < 40)
			$display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// Advances the list state by one item and queues the result it causes.
	task automatic execute_item(input dlc_item_t it);
		dlc_result_t r;
		logic [POS_W-1:0] v;
		logic [POS_W-1:0] h;
		logic [POS_W-1:0] pv;
		logic [POS_W-1:0] ph;
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] floor_off;
		logic blit;
		r = '0;
		v = it.beam_v[POS_W-1:0];
		h = it.beam_h;
		if (it.kind == KIND_UNUSED)
			return;
		if (it.kind == KIND_RESTART || it.kind == KIND_JUMP) begin
			list_pc = (it.kind == KIND_RESTART) ? cfg_list_start : it.jump_address;
			list_waiting = 1'b0;
			r.event_res = EV_RELOAD;
		end else if (list_waiting) begin
			if (v < wait_v) begin
				r.event_res = EV_HOLD;
				r.hold_rest_of_line = 1'b1;
			end else if (v == wait_v && h < wait_h) begin
				r.event_res = EV_HOLD;
				if (wait_h > cfg_last_h)
					r.hold_rest_of_line = 1'b1;
				else
					r.release_h = wait_h;
			end else if (wait_blit && it.blitter_busy) begin
				r.event_res = EV_HOLD;
				r.hold_rest_of_line = 1'b1;
			end else begin
				wait_blit = 1'b0;
				list_waiting = 1'b0;
				list_pc = list_pc + STEP_ONE;
				r.event_res = EV_RELEASE;
			end
		end else if (!it.instr_word[0]) begin
			off = {it.instr_word[8:1], 1'b0};
			floor_off = {1'b0, FLOOR_BASE} - {2'b00, cfg_danger, 5'd0};
			list_pc = list_pc + STEP_ONE;
			if (off >= floor_off) begin
				r.event_res = EV_WRITE;
				r.reg_offset = off;
				r.reg_data = it.param_word;
			end else begin
				// Protected register: the list parks on a wait for line 0xff, column 0xfe.
				list_waiting = 1'b1;
				wait_v = STOP_LINE;
				wait_h = STOP_COLUMN;
				r.event_res = EV_STOP;
			end
		end else begin
			// Bit 7 of the vertical compare is always enabled.
			pv = it.instr_word[15:8] & {1'b1, it.param_word[14:8]};
			ph = it.instr_word[7:0] & it.param_word[7:0] & 8'hfe;
			blit = !it.param_word[15];
			if (!it.param_word[0]) begin
				list_waiting = 1'b1;
				wait_v = pv;
				wait_h = ph;
				wait_blit = blit;
				r.event_res = EV_ARMED;
			end else if (v < pv || (v == pv && h < ph) || (blit && it.blitter_busy)) begin
				list_pc = list_pc + STEP_ONE;
				r.event_res = EV_SKIP_NO;
			end else begin
				list_pc = list_pc + STEP_TWO;
				r.event_res = EV_SKIP_YES;
			end
		end
		r.fetch_address = list_pc;
		due_results.push_back(r);
	endtask

	task automatic send_item(input dlc_item_t it);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {1'b0, it.jump_address, it.param_word, it.instr_word, it.blitter_busy,
			it.beam_h, it.beam_v};
		do
			@(posedge clk);
		while (!s_tready);
		execute_item(it);
	endtask

	task automatic send_slot(input logic [LINE_W-1:0] v, input logic [POS_W-1:0] h,
			input logic busy, input logic [WORD_W-1:0] inst, input logic [WORD_W-1:0] param);
		dlc_item_t it;
		it.kind = KIND_SLOT;
		it.beam_v = v;
		it.beam_h = h;
		it.blitter_busy = busy;
		it.instr_word = inst;
		it.param_word = param;
		it.jump_address = FETCH_W'($urandom);
		send_item(it);
	endtask

	task automatic send_reload(input logic [KIND_W-1:0] kind, input logic [FETCH_W-1:0] addr);
		dlc_item_t it;
		it.kind = kind;
		it.beam_v = LINE_W'($urandom);
		it.beam_h = POS_W'($urandom);
		it.blitter_busy = 1'($urandom);
		it.instr_word = WORD_W'($urandom);
		it.param_word = WORD_W'($urandom);
		it.jump_address = addr;
		send_item(it);
	endtask

	// Waits until every result is back, then idles a drain period so dropped items clear.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LIST_START: cfg_list_start = value[FETCH_W-1:0];
			REG_DANGER:     cfg_danger = value[DL_W-1:0];
			default:        cfg_last_h = value[POS_W-1:0];
		endcase
	endtask

	task automatic set_config(input logic [FETCH_W-1:0] start, input logic [DL_W-1:0] danger,
			input logic [POS_W-1:0] last_h);
		settle();
		apb_write(REG_LIST_START, 32'(start));
		apb_write(REG_DANGER, 32'(danger));
		apb_write(REG_LAST_H, 32'(last_h));
	endtask

	task automatic test_reload_and_wrap();
		send_reload(KIND_RESTART, '0);
		send_reload(KIND_UNUSED, '1);
		// Write to the top register; the counter wraps past the top of memory.
		send_slot(9'h000, 8'h00, 1'b0, 16'h01fe, 16'hffff);
	endtask

	task automatic test_move_floor();
		send_slot(9'h000, 8'h00, 1'b0, 16'hfe7e, 16'h5a5a);
		send_slot(9'h1ff, 8'hfd, 1'b0, 16'hffff, 16'hffff);
		send_slot(9'h0ff, 8'hfe, 1'b1, 16'h0000, 16'h0000);
		send_slot(9'h000, 8'h00, 1'b0, 16'h0080, 16'h1234);
	endtask

	task automatic test_wait_release();
		send_slot(9'h000, 8'h00, 1'b0, 16'h8051, 16'h7ffe);
		send_slot(9'h07f, 8'hff, 1'b0, 16'h0000, 16'h0000);
		send_slot(9'h180, 8'h10, 1'b0, 16'h0000, 16'h0000);
		send_slot(9'h080, 8'h50, 1'b1, 16'h0000, 16'h0000);
		// A restart drops the wait but keeps the blitter flag for the next stop.
		send_reload(KIND_RESTART, '0);
		send_slot(9'h000, 8'h00, 1'b0, 16'h0000, 16'hffff);
		send_slot(9'h0ff, 8'hff, 1'b1, 16'h0000, 16'h0000);
		send_slot(9'h0ff, 8'hff, 1'b0, 16'h0000, 16'h0000);
	endtask

	task automatic test_skip();
		send_slot(9'h07f, 8'hff, 1'b0, 16'hffff, 16'h0001);
		send_slot(9'h080, 8'h00, 1'b1, 16'hffff, 16'h0001);
		send_slot(9'h080, 8'h00, 1'b0, 16'hffff, 16'h0001);
		send_slot(9'h044, 8'h0f, 1'b1, 16'h4411, 16'hffff);
		send_slot(9'h044, 8'h10, 1'b1, 16'h4411, 16'hffff);
	endtask

	task automatic test_jump_wrap();
		send_reload(KIND_JUMP, 21'h1ffffc);
		send_slot(9'h000, 8'h00, 1'b0, 16'h0001, 16'h8001);
		send_reload(KIND_JUMP, 21'h1fffff);
		send_slot(9'h000, 8'h00, 1'b0, 16'hfffe, 16'h0000);
	endtask

	// Mostly instruction slots, with beam positions steered onto the compare points.
	task automatic test_random_traffic(input int count);
		dlc_item_t it;
		int pick;
		logic [POS_W-1:0] tv;
		logic [POS_W-1:0] th;
		bit steer;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			it.kind = (pick < 4) ? KIND_RESTART : (pick < 7) ? KIND_JUMP :
				(pick < 10) ? KIND_UNUSED : KIND_SLOT;
			it.jump_address = ($urandom_range(0, 7) == 0) ? 21'h1fffff - FETCH_W'($urandom_range(0, 7))
				: FETCH_W'($urandom);
			it.instr_word = WORD_W'($urandom);
			it.param_word = WORD_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				it.instr_word[0] = 1'b0;
			end else begin
				it.instr_word[0] = 1'b1;
				it.param_word[0] = (pick >= 75);
			end
			it.beam_v = LINE_W'($urandom);
			it.beam_h = POS_W'($urandom);
			it.blitter_busy = ($urandom_range(0, 2) == 0);
			steer = ($urandom_range(0, 9) < 6);
			if (list_waiting) begin
				tv = wait_v;
				th = wait_h;
			end else begin
				tv = it.instr_word[15:8] & {1'b1, it.param_word[14:8]};
				th = it.instr_word[7:0] & it.param_word[7:0] & 8'hfe;
				steer = steer && it.instr_word[0] && it.param_word[0];
			end
			if (steer) begin
				it.beam_v = {1'($urandom), tv};
				case ($urandom_range(0, 3))
					0:       it.beam_h = th - 8'd1;
					1:       it.beam_h = th;
					2:       it.beam_h = th + 8'd1;
					default: it.beam_h = POS_W'($urandom);
				endcase
			end
			send_item(it);
		end
	endtask

	always @(posedge clk) begin
		if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dlc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[31:0], '0);
			end else begin
				want = due_results.pop_front();
				if (m_tdata[2:0] != want.event_res)
					report_mismatch("event_res", 32'(m_tdata[2:0]), 32'(want.event_res));
				if (m_tdata[11:3] != want.reg_offset)
					report_mismatch("reg_offset", 32'(m_tdata[11:3]), 32'(want.reg_offset));
				if (m_tdata[27:12] != want.reg_data)
					report_mismatch("reg_data", 32'(m_tdata[27:12]), 32'(want.reg_data));
				if (m_tdata[48:28] != want.fetch_address)
					report_mismatch("fetch_address", 32'(m_tdata[48:28]),
						32'(want.fetch_address));
				if (m_tdata[49] != want.hold_rest_of_line)
					report_mismatch("hold_rest_of_line", 32'(m_tdata[49]),
						32'(want.hold_rest_of_line));
				if (m_tdata[57:50] != want.release_h)
					report_mismatch("release_h", 32'(m_tdata[57:50]), 32'(want.release_h));
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(21'h1ffffc, 2'd0, LAST_H_RESET);
		test_reload_and_wrap();
		test_move_floor();
		test_wait_release();
		test_skip();
		test_jump_wrap();

		set_config(FETCH_W'($urandom), 2'd0, LAST_H_RESET);
		test_random_traffic(300);
		set_config(21'h1fffff, 2'd3, 8'hff);
		test_random_traffic(300);
		set_config(21'h000000, 2'd1, 8'h00);
		test_random_traffic(300);
		set_config(FETCH_W'($urandom), 2'd2, POS_W'($urandom));
		test_random_traffic(300);
		set_config(FETCH_W'($urandom), 2'd3, 8'hfd);
		idle_on = 1'b0;
		test_random_traffic(350);

		settle();
		if (fail_count == 0)
			$display("display_list_coprocessor: match");
		else
			$display("display_list_coprocessor: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("display_list_coprocessor: mismatch");
		$finish;
	end

endmodule
